FILE: sv/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the bounded set table.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 7;

    // Action codes carried on s_tuser
    localparam logic [ACTION_W-1:0] ACT_CONTAINS = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd2;

    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

    // One result beat: success flag and the count after the action
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

FILE: sv/bst_ram.sv
// ----------------------------------------------------------------------------
// bst_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bst_ctrl.sv
// ----------------------------------------------------------------------------
// bst_ctrl
// Sequencer: scans the table one entry a cycle, then commits add or remove.
// ----------------------------------------------------------------------------
module bst_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request side
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [bst_pkg::ACTION_W-1:0]        req_action,
    input  logic [bst_pkg::VALUE_W-1:0]         req_value,
    input  logic [bst_pkg::COUNT_W-1:0]         cap_limit,
    // result side
    input  logic                                res_free,
    output logic                                res_load,
    output bst_pkg::result_t                    res,
    // memory port
    output logic                                ram_wr_en,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_wr_addr,
    output logic [bst_pkg::VALUE_W-1:0]         ram_wr_data,
    output logic                                ram_rd_en,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_rd_addr,
    input  logic [bst_pkg::VALUE_W-1:0]         ram_rd_data
);

    localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW        = bst_pkg::COUNT_W;
    localparam int DEPTH_CAP = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_LAST_RD = 3'd2;
    localparam logic [2:0] ST_LAST_WT = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 pend_idx_reg, pend_idx_next;
    logic                          pend_reg, pend_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 slot_reg, slot_next;
    logic [bst_pkg::ACTION_W-1:0]  act_reg, act_next;
    logic [bst_pkg::VALUE_W-1:0]   val_reg, val_next;
    logic [bst_pkg::VALUE_W-1:0]   last_reg, last_next;

    logic [CW-1:0] eff_cap;
    logic          hit;
    logic          issue;
    logic [CW-1:0] count_dec;

    assign eff_cap   = (cap_limit > CW'(DEPTH_CAP)) ? CW'(DEPTH_CAP) : cap_limit;
    assign hit       = pend_reg && (ram_rd_data == val_reg);
    assign issue     = (state_reg == ST_SCAN) && !hit && (idx_reg < count_reg);
    assign count_dec = count_reg - CW'(1);
    assign req_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        res_load      = 1'b0;
        res.ok        = 1'b0;
        res.count     = count_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = AW'(count_reg);
        ram_wr_data   = val_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = AW'(idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    act_next   = req_action;
                    val_next   = req_value;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    if (req_action == bst_pkg::ACT_CONTAINS ||
                        req_action == bst_pkg::ACT_ADD ||
                        req_action == bst_pkg::ACT_REMOVE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // compare the entry read last cycle, issue the next read
                ram_rd_en = issue;
                if (hit) begin
                    found_next = 1'b1;
                    slot_next  = pend_idx_reg;
                    pend_next  = 1'b0;
                    state_next = (act_reg == bst_pkg::ACT_REMOVE) ? ST_LAST_RD : ST_FINISH;
                end else begin
                    pend_next     = issue;
                    pend_idx_next = idx_reg;
                    if (issue) begin
                        idx_next = idx_reg + CW'(1);
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LAST_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(count_dec);
                state_next  = ST_LAST_WT;
            end
            ST_LAST_WT: begin
                last_next  = ram_rd_data;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // commit only when the output register can take the beat
                if (res_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (act_reg)
                        bst_pkg::ACT_CONTAINS: begin
                            res.ok = found_reg;
                        end
                        bst_pkg::ACT_ADD: begin
                            if (!found_reg && count_reg < eff_cap) begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                                res.ok     = 1'b1;
                                res.count  = count_reg + CW'(1);
                            end
                        end
                        bst_pkg::ACT_REMOVE: begin
                            if (found_reg) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = AW'(slot_reg);
                                ram_wr_data = last_reg;
                                count_next  = count_dec;
                                res.ok      = 1'b1;
                                res.count   = count_dec;
                            end
                        end
                        default: begin
                            res.ok = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        act_reg      <= act_next;
        val_reg      <= val_next;
        last_reg     <= last_next;
    end

endmodule

FILE: sv/bounded_set_table.sv
// ----------------------------------------------------------------------------
// bounded_set_table
// Unordered set of distinct 32-bit values with contains, add and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser carries the action (contains, add, remove),
//   s_tdata the 32-bit value. Every input beat yields exactly one output beat
//   on m_*: m_tuser is the success flag, m_tdata the element count after the
//   action.
//   The table lives in one RAM. An action scans the live entries one per
//   cycle (pipelined against the registered RAM read); a remove also reads
//   the last live entry before writing it into the freed slot. The scan over
//   the RAM read port sets how long an item takes.
//   Only one item is in flight at a time; s_tready rises again once the
//   result has moved into the output register, so the next item may start
//   while the previous result still waits for m_tready.
//   cfg_wr_en/cfg_wr_data write the capacity limit (saturated to the table
//   depth); write it only while the block is idle. Lowering it below the
//   count keeps the stored elements and only blocks further adds.
//   Reset (aresetn low, synchronous) empties the set and sets the capacity to
//   64. The RAM needs no clearing: only entries below the count are read.
//   A stalled receiver holds the output beat; the sequencer then waits before
//   committing the next result.
// ----------------------------------------------------------------------------
module bounded_set_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: capacity limit
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] count, [7] zero
    output logic        m_tuser    // [0] ok
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [bst_pkg::COUNT_W-1:0] cap_reg;
    logic                        m_tvalid_reg;
    bst_pkg::result_t            res_reg;

    bst_pkg::result_t            res;
    logic                        res_load;
    logic                        res_free;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [bst_pkg::VALUE_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [bst_pkg::VALUE_W-1:0] ram_rd_data;

    // Capacity register: plain write, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bst_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Output register is free when empty or being drained this cycle
    assign res_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Hold the payload until a new result is loaded
    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.count};
    assign m_tuser  = res_reg.ok;

    bst_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_action  (s_tuser),
        .req_value   (s_tdata),
        .cap_limit   (cap_reg),
        .res_free    (res_free),
        .res_load    (res_load),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    bst_ram #(
        .WIDTH (bst_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: sv/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks for the bounded set table, bound to the top level.
// ----------------------------------------------------------------------------
module bst_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);

    localparam int DEPTH_CAP = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;

    logic       in_beat, out_beat;
    logic [6:0] last_cnt_reg;
    logic [1:0] pend_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // track last reported count and items awaiting a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cnt_reg <= '0;
            pend_reg     <= '0;
        end else begin
            if (out_beat) begin
                last_cnt_reg <= m_tdata[6:0];
            end
            pend_reg <= pend_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7] == 1'b0 && m_tdata[6:0] <= 7'(DEPTH_CAP))
        else $error("count above table depth");

    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat |-> (m_tuser && (m_tdata[6:0] == last_cnt_reg + 7'd1 ||
                                  m_tdata[6:0] + 7'd1 == last_cnt_reg ||
                                  m_tdata[6:0] == last_cnt_reg)) ||
                     (!m_tuser && m_tdata[6:0] == last_cnt_reg))
        else $error("count moved by more than one or moved on failure");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted input");

endmodule

bind bounded_set_table bst_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bst_checker (.*);

FILE: dv/bst_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_result_check
// Watches both streams of the bounded set table and the capacity writes,
// keeps its own copy of the set, and checks every result beat in order.
// ----------------------------------------------------------------------------
module bst_result_check #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          outstanding
);

    logic [bst_pkg::VALUE_W-1:0] members [TABLE_DEPTH];
    logic [bst_pkg::COUNT_W-1:0] member_count;
    logic [bst_pkg::COUNT_W-1:0] cap_limit;
    bst_pkg::result_t            pending_results [$];

    // Apply one action to the local set and return the result it yields.
    function automatic bst_pkg::result_t apply_set_action(
            logic [bst_pkg::ACTION_W-1:0] act,
            logic [bst_pkg::VALUE_W-1:0]  val);
        int               hit;
        int               lim;
        int               i;
        bst_pkg::result_t res;
        hit = -1;
        for (i = 0; i < member_count; i++) begin
            if (hit < 0 && members[i] == val)
                hit = i;
        end
        lim = (cap_limit > TABLE_DEPTH) ? TABLE_DEPTH : cap_limit;
        res.ok = 1'b0;
        case (act)
            bst_pkg::ACT_CONTAINS: begin
                res.ok = (hit >= 0);
            end
            bst_pkg::ACT_ADD: begin
                if (hit < 0 && member_count < lim) begin
                    members[member_count] = val;
                    member_count++;
                    res.ok = 1'b1;
                end
            end
            bst_pkg::ACT_REMOVE: begin
                // last live entry fills the hole, itself when it is the hit
                if (hit >= 0) begin
                    members[hit] = members[member_count - 1];
                    member_count--;
                    res.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.count = member_count;
        return res;
    endfunction

    always @(posedge aclk) begin
        bst_pkg::result_t want;
        if (!aresetn) begin
            member_count = '0;
            cap_limit    = bst_pkg::CAP_RESET;
            pending_results.delete();
        end else begin
            // retire first: a result leaving now belongs to an older beat
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: ok=%0d count=%0d",
                           m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== {1'b0, want.count}) begin
                        $error("count: expected %0d, got %0d", want.count, m_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_set_action(s_tuser, s_tdata));
            if (cfg_wr_en)
                cap_limit = cfg_wr_data;
        end
        outstanding = pending_results.size();
    end

endmodule

FILE: dv/bounded_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_table_tb
// Drives contains, add and remove beats and the unused action code into the
// set table under a range of capacity settings, with random idling on both
// streams; a separate result checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module bounded_set_table_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 148;
    localparam int POOL_MAX    = 96;
    localparam int CYCLE_LIMIT = 1_000_000;

    // the one action code the block has no use for
    localparam logic [bst_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic [1:0]  s_tuser;    // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [6:0] count, [7] zero
    logic        m_tuser;    // [0] ok

    int mismatches;
    int outstanding;
    int cycles;

    // idling controls: calm for both sides, stall_pct for the receiver, gap_pct for the sender
    bit calm;
    int stall_pct;
    int gap_pct;

    // values the random beats draw from, so that hits are common
    logic [31:0] value_pool [POOL_MAX];

    // per-phase capacity, add share and pool size
    int phase_cap  [PHASES] = '{127, 64, 20, 0, 1, 100, 63, 64, 5, 127};
    int phase_add  [PHASES] = '{80, 40, 55, 50, 60, 45, 50, 35, 50, 50};
    int phase_pool [PHASES] = '{90, 90, 30, 40, 8, 70, 70, 96, 12, 40};

    bounded_set_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    bst_result_check #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a hung handshake or a lost result ends up here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL bounded_set_table");
        $finish;
    end

    // Receiver: hold m_tready low for random bursts, never while calm.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Present one beat and hold it until the block takes it. The valid is
    // left high so that a following beat goes out back to back.
    task automatic push_beat(logic [bst_pkg::ACTION_W-1:0] act,
                             logic [bst_pkg::VALUE_W-1:0]  val);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid for a random burst, now and then.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Hold the sender until every pending result has come back. Sample the
    // checker's count on the falling edge, clear of the update at the rising
    // one, then realign to a rising edge for the next drive.
    task automatic await_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Capacity writes only ever go in while the block is idle.
    task automatic write_capacity(logic [6:0] cap);
        await_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random beat: mostly pool values so that hits and duplicates are
    // frequent, the odd fully random value, and now and then the unused code.
    task automatic random_beat(int add_pct, int pool_n);
        logic [bst_pkg::ACTION_W-1:0] act;
        logic [bst_pkg::VALUE_W-1:0]  val;
        int                           roll;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            act = bst_pkg::ACT_ADD;
        else if (roll < add_pct + (100 - add_pct) * 2 / 5)
            act = bst_pkg::ACT_REMOVE;
        else if (roll < 96)
            act = bst_pkg::ACT_CONTAINS;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 99) < 85)
            val = value_pool[$urandom_range(0, pool_n - 1)];
        else
            val = $urandom();
        push_beat(act, val);
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= bst_pkg::ACT_CONTAINS;
        calm        = 1'b0;
        stall_pct   = 15;
        gap_pct     = 15;

        for (int i = 0; i < POOL_MAX; i++)
            value_pool[i] = $urandom();
        // keep the extremes in the pool
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset capacity first.
        push_beat(bst_pkg::ACT_CONTAINS, 32'h0000_0000);   // empty set: miss
        push_beat(bst_pkg::ACT_REMOVE,   32'h8000_0000);   // empty set: nothing to drop
        push_beat(ACT_UNUSED,            32'hFFFF_FFFF);   // unused code on an empty set
        push_beat(bst_pkg::ACT_ADD,      32'h8000_0000);
        push_beat(bst_pkg::ACT_ADD,      32'h7FFF_FFFF);
        push_beat(bst_pkg::ACT_ADD,      32'h0000_0000);
        push_beat(bst_pkg::ACT_ADD,      32'hFFFF_FFFF);
        push_beat(bst_pkg::ACT_ADD,      32'h7FFF_FFFF);   // duplicate refused
        push_beat(bst_pkg::ACT_CONTAINS, 32'h8000_0000);
        push_beat(bst_pkg::ACT_CONTAINS, 32'h0000_0005);
        push_beat(ACT_UNUSED,            32'h0000_0000);   // unused code, count unchanged
        push_beat(bst_pkg::ACT_REMOVE,   32'h8000_0000);   // first slot refilled from the end
        push_beat(bst_pkg::ACT_CONTAINS, 32'hFFFF_FFFF);   // moved entry still found
        push_beat(bst_pkg::ACT_REMOVE,   32'h0000_0000);   // last live entry onto itself
        push_beat(bst_pkg::ACT_REMOVE,   32'h0000_0000);   // already gone

        // Lower the capacity below the count: adds blocked, the rest works.
        write_capacity(7'd1);
        push_beat(bst_pkg::ACT_ADD,      32'h1234_5678);
        push_beat(bst_pkg::ACT_CONTAINS, 32'h7FFF_FFFF);
        push_beat(bst_pkg::ACT_REMOVE,   32'hFFFF_FFFF);
        push_beat(bst_pkg::ACT_ADD,      32'h1234_5678);   // count now equals capacity
        push_beat(bst_pkg::ACT_ADD,      32'h7FFF_FFFF);   // duplicate at full capacity
        push_beat(bst_pkg::ACT_REMOVE,   32'h7FFF_FFFF);
        push_beat(bst_pkg::ACT_ADD,      32'h1234_5678);   // room again

        // Random phases. The set carries over from phase to phase, so the
        // first one fills the table to its depth and later ones cut the
        // capacity under a populated set.
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(7'(phase_cap[p]));
            stall_pct = (p == 7) ? 0 : 12;
            gap_pct   = (p == 7) ? 0 : 12;
            calm      = (p == PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // once, let the block run completely dry mid-phase
                if (p == 4 && n == PHASE_BEATS / 2)
                    await_drain();
                sender_gap();
                random_beat(phase_add[p], phase_pool[p]);
            end
        end

        await_drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS bounded_set_table");
        else
            $display("FAIL bounded_set_table");
        $finish;
    end

endmodule
